// File: hdl/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Types, codes and helpers shared by the client session table modules.
// ----------------------------------------------------------------------------
package cst_pkg;

  // packet and command modes
  typedef enum logic [2:0] {
    MODE_DATA    = 3'd0,
    MODE_ALIVE   = 3'd1,
    MODE_PING    = 3'd2,
    MODE_CONNECT = 3'd3,
    MODE_DISC    = 3'd4,
    MODE_SWEEP   = 3'd5,
    MODE_DROP    = 3'd6,
    MODE_RSVD    = 3'd7
  } mode_e;

  // result actions
  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_DATA_OK  = 4'd1,
    ACT_STALE    = 4'd2,
    ACT_ALIVE    = 4'd3,
    ACT_REPLY    = 4'd4,
    ACT_ACCEPT   = 4'd5,
    ACT_REJECT   = 4'd6,
    ACT_LEFT     = 4'd7,
    ACT_TIMEOUT  = 4'd8,
    ACT_PING     = 4'd9,
    ACT_DROPPED  = 4'd10,
    ACT_UNKNOWN  = 4'd11
  } act_e;

  // configuration register indexes
  localparam logic [2:0] REG_CLIENT_CAP   = 3'd0;
  localparam logic [2:0] REG_ALLOW_CONN   = 3'd1;
  localparam logic [2:0] REG_TIMEOUT      = 3'd2;
  localparam logic [2:0] REG_IDLE_PAUSE   = 3'd3;
  localparam logic [2:0] REG_MIN_PING_GAP = 3'd4;
  localparam logic [2:0] REG_MAX_PING_GAP = 3'd5;

  // kind of table search an item needs
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_UID   = 2'd1,
    KIND_PEER  = 2'd2,
    KIND_SWEEP = 2'd3
  } kind_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] now;
    logic [31:0] uid;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] stamp;
    logic        common;
  } item_t;

  typedef struct packed {
    item_t item;
    kind_e kind;
  } cls_item_t;

  typedef struct packed {
    logic [4:0]  client_cap;
    logic        allow_conn;
    logic [15:0] timeout;
    logic [15:0] idle_pause;
    logic [15:0] min_gap;
    logic [15:0] max_gap;
  } cfg_t;

  typedef struct packed {
    logic [31:0] uid;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] heard;
    logic [31:0] sent;
    logic [31:0] psent;
    logic [31:0] stamp;
    logic [31:0] ping;
  } entry_t;

  typedef struct packed {
    act_e        action;
    logic [31:0] uid;
    logic [3:0]  slot;
    logic [31:0] ping;
    logic [31:0] addr;
    logic [15:0] port;
    logic        last;
  } res_t;

  function automatic res_t mk_res(act_e act, logic [31:0] uid, logic [3:0] slot,
                                  logic [31:0] ping, logic [31:0] addr,
                                  logic [15:0] port);
    res_t r;
    r.action = act;
    r.uid    = uid;
    r.slot   = slot;
    r.ping   = ping;
    r.addr   = addr;
    r.port   = port;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/cst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_front
// Input queue: accepts items, classifies the table search each one needs.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  cst_pkg::item_t    item_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output cst_pkg::cls_item_t item_o
);
  import cst_pkg::*;

  cls_item_t  buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cls_item_t  cls;
  logic       do_push, do_pop;

  // classification of the incoming item
  always_comb begin
    cls.item = item_i;
    case (item_i.mode)
      MODE_DATA, MODE_ALIVE, MODE_PING, MODE_DROP: cls.kind = KIND_UID;
      MODE_CONNECT, MODE_DISC:                     cls.kind = KIND_PEER;
      MODE_SWEEP:                                  cls.kind = KIND_SWEEP;
      default:                                     cls.kind = KIND_NONE;
    endcase
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rd_q];
  assign do_push      = push && !full;
  assign do_pop       = item_take_i && item_valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= cls;
    end
  end

endmodule

// File: hdl/cst_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_res_fifo
// Two-entry result queue between the table engine and the result port.
// ----------------------------------------------------------------------------
module cst_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  cst_pkg::res_t wr_data_i,
  output logic          wr_full_o,
  output logic          empty,
  input  logic          pop,
  output cst_pkg::res_t rd_data_o
);
  import cst_pkg::*;

  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_full_o = (cnt_q == 2'd2);
  assign empty     = (cnt_q == 2'd0);
  assign rd_data_o = mem_q[rd_q];
  assign do_wr     = wr_en_i && !wr_full_o;
  assign do_rd     = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= wr_data_i;
    end
  end

endmodule

// File: hdl/cst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_back
// Table engine: scans the client table one entry a cycle (a sweep hit stalls
// on a full result queue), updates, appends or compacts it, and queues results.
// ----------------------------------------------------------------------------
module cst_back #(
  parameter int SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_pkg::cfg_t      cfg_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  cst_pkg::cls_item_t item_i,
  output logic               res_wr_o,
  output cst_pkg::res_t      res_o,
  input  logic               res_full_i
);
  import cst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ACT   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  entry_t      tab_q [SLOTS];
  logic [CW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [31:0] nuid_q, nuid_d;
  item_t       it_q, it_d;
  kind_e       kind_q, kind_d;
  logic        found_q, found_d;
  res_t        hold_q, hold_d;
  logic        holdv_q, holdv_d;

  entry_t      cur, wd;
  logic        we, shift_en;
  logic [IW-1:0] wi;
  logic [31:0] dh, ds, dp, idx32, cnt32;
  logic [3:0]  slot4, cslot4;
  logic        tmo, pgo, at_end, m_uid, m_peer, room;
  logic [8:0]  limit;

  // current entry and its age figures
  assign cur    = tab_q[idx_q[IW-1:0]];
  assign dh     = it_q.now - cur.heard;
  assign ds     = it_q.now - cur.sent;
  assign dp     = it_q.now - cur.psent;
  assign tmo    = dh > {16'd0, cfg_i.timeout};
  assign pgo    = (dh > {16'd0, cfg_i.idle_pause} && ds > {16'd0, cfg_i.min_gap}) ||
                  dp > {16'd0, cfg_i.max_gap};
  assign at_end = (idx_q == cnt_q);
  assign m_uid  = (cur.uid == it_q.uid);
  assign m_peer = (cur.addr == it_q.addr) && (cur.port == it_q.port);
  assign idx32  = 32'(idx_q);
  assign cnt32  = 32'(cnt_q);
  assign slot4  = idx32[3:0];
  assign cslot4 = cnt32[3:0];
  assign limit  = ({4'd0, cfg_i.client_cap} > 9'(SLOTS)) ? 9'(SLOTS)
                                                        : {4'd0, cfg_i.client_cap};
  assign room   = 9'(cnt_q) < limit;

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    nuid_d      = nuid_q;
    it_d        = it_q;
    kind_d      = kind_q;
    found_d     = found_q;
    hold_d      = hold_q;
    holdv_d     = holdv_q;
    item_take_o = 1'b0;
    res_wr_o    = 1'b0;
    res_o       = hold_q;
    res_o.last  = 1'b0;
    we          = 1'b0;
    wi          = idx_q[IW-1:0];
    wd          = cur;
    shift_en    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          it_d        = item_i.item;
          kind_d      = item_i.kind;
          idx_d       = '0;
          found_d     = 1'b0;
          holdv_d     = 1'b0;
          state_d     = (item_i.kind == KIND_NONE) ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (at_end) begin
          state_d = (kind_q == KIND_SWEEP) ? S_FIN : S_ACT;
        end else begin
          case (kind_q)
            KIND_UID, KIND_PEER: begin
              if ((kind_q == KIND_UID) ? m_uid : m_peer) begin
                found_d = 1'b1;
                state_d = S_ACT;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
            KIND_SWEEP: begin
              if (tmo || pgo) begin
                if (!(holdv_q && res_full_i)) begin
                  // flush the earlier result, keep the new one for the last flag
                  res_wr_o = holdv_q;
                  holdv_d  = 1'b1;
                  hold_d   = mk_res(tmo ? ACT_TIMEOUT : ACT_PING, cur.uid, slot4, 32'd0,
                                    cur.addr, cur.port);
                  if (tmo) begin
                    state_d = S_SHIFT;
                  end else begin
                    we       = 1'b1;
                    wd.sent  = it_q.now;
                    wd.psent = it_q.now;
                    idx_d    = idx_q + 1'b1;
                  end
                end
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_ACT: begin
        state_d = S_FIN;
        case (it_q.mode)
          MODE_DATA: begin
            if (found_q) begin
              we       = 1'b1;
              wd.heard = it_q.now;
              holdv_d  = 1'b1;
              if (it_q.common && it_q.stamp < cur.stamp) begin
                hold_d = mk_res(ACT_STALE, it_q.uid, slot4, 32'd0, 32'd0, 16'd0);
              end else begin
                if (it_q.common) wd.stamp = it_q.stamp;
                hold_d = mk_res(ACT_DATA_OK, it_q.uid, slot4, 32'd0, 32'd0, 16'd0);
              end
            end
          end
          MODE_ALIVE: begin
            if (found_q) begin
              we       = 1'b1;
              wd.heard = it_q.now;
              wd.ping  = dp;
              holdv_d  = 1'b1;
              hold_d   = mk_res(ACT_ALIVE, it_q.uid, slot4, dp, 32'd0, 16'd0);
            end
          end
          MODE_PING: begin
            if (found_q) begin
              we       = 1'b1;
              wd.heard = it_q.now;
              wd.sent  = it_q.now;
            end
            holdv_d = 1'b1;
            hold_d  = mk_res(ACT_REPLY, it_q.uid, found_q ? slot4 : 4'd0, 32'd0,
                             it_q.addr, it_q.port);
          end
          MODE_CONNECT: begin
            holdv_d = 1'b1;
            if (!found_q && cfg_i.allow_conn && room) begin
              we       = 1'b1;
              wi       = cnt_q[IW-1:0];
              wd.uid   = nuid_q + 32'd1;
              wd.addr  = it_q.addr;
              wd.port  = it_q.port;
              wd.heard = it_q.now;
              wd.sent  = it_q.now;
              wd.psent = 32'd0;
              wd.stamp = it_q.stamp;
              wd.ping  = 32'd0;
              nuid_d   = nuid_q + 32'd1;
              cnt_d    = cnt_q + 1'b1;
              hold_d   = mk_res(ACT_ACCEPT, nuid_q + 32'd1, cslot4, 32'd0,
                                it_q.addr, it_q.port);
            end else begin
              hold_d = mk_res(ACT_REJECT, 32'd0, 4'd0, 32'd0, it_q.addr, it_q.port);
            end
          end
          MODE_DISC: begin
            if (found_q) begin
              holdv_d = 1'b1;
              hold_d  = mk_res(ACT_LEFT, cur.uid, slot4, 32'd0, 32'd0, 16'd0);
              state_d = S_SHIFT;
            end
          end
          MODE_DROP: begin
            holdv_d = 1'b1;
            if (found_q) begin
              hold_d  = mk_res(ACT_DROPPED, it_q.uid, slot4, 32'd0, cur.addr, cur.port);
              state_d = S_SHIFT;
            end else begin
              hold_d = mk_res(ACT_UNKNOWN, it_q.uid, 4'd0, 32'd0, 32'd0, 16'd0);
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        shift_en = 1'b1;
        cnt_d    = cnt_q - 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!holdv_q) begin
          state_d = S_IDLE;
        end else if (!res_full_i) begin
          res_wr_o   = 1'b1;
          res_o.last = 1'b1;
          holdv_d    = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      nuid_q  <= 32'd0;
      holdv_q <= 1'b0;
      idx_q   <= '0;
      found_q <= 1'b0;
      kind_q  <= KIND_NONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nuid_q  <= nuid_d;
      holdv_q <= holdv_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      kind_q  <= kind_d;
    end
  end

  // item and held result
  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    hold_q <= hold_d;
  end

  // client table: compaction above the removed entry, or one entry write
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (IW'(i) >= idx_q[IW-1:0]) begin
          tab_q[i] <= tab_q[i + 1];
        end
      end
    end else if (we) begin
      tab_q[wi] <= wd;
    end
  end

endmodule

// File: hdl/client_session_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_session_table_core
// Server-side session table for a datagram link: tracks clients, answers
// packets, sweeps for pings and timeouts.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  input    | push / full             | mode, now, pkt_uid, src_addr, src_port,
//           |                         | time_stamp, is_common
//  result   | empty / pop             | action, uid, slot, ping_ms, dest_addr,
//           |                         | dest_port, last
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  an item's run time grows with N, the entries scanned (at most the client
//  count), through the one-entry-a-cycle table scan in the engine
//  a sweep item with many pings runs at one result a cycle while results drain
//  reset empties the table at once; no clearing pass
//  a full result queue stalls the engine; a two-item input queue keeps taking items
// ----------------------------------------------------------------------------
module client_session_table_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode_i,
  input  logic [31:0] now_i,
  input  logic [31:0] pkt_uid_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] time_stamp_i,
  input  logic        is_common_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  action_o,
  output logic [31:0] uid_o,
  output logic [3:0]  slot_o,
  output logic [31:0] ping_ms_o,
  output logic [31:0] dest_addr_o,
  output logic [15:0] dest_port_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import cst_pkg::*;

  cfg_t      cfg_q;
  item_t     in_item;
  cls_item_t f_item;
  logic      f_valid, f_take, r_wr, r_full;
  res_t      r_in, r_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.client_cap <= 5'd16;
      cfg_q.allow_conn <= 1'b1;
      cfg_q.timeout    <= 16'd5000;
      cfg_q.idle_pause <= 16'd500;
      cfg_q.min_gap    <= 16'd250;
      cfg_q.max_gap    <= 16'd2000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CLIENT_CAP:   cfg_q.client_cap <= cfg_data_i[4:0];
        REG_ALLOW_CONN:   cfg_q.allow_conn <= cfg_data_i[0];
        REG_TIMEOUT:      cfg_q.timeout    <= cfg_data_i;
        REG_IDLE_PAUSE:   cfg_q.idle_pause <= cfg_data_i;
        REG_MIN_PING_GAP: cfg_q.min_gap    <= cfg_data_i;
        REG_MAX_PING_GAP: cfg_q.max_gap    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input item bundle
  always_comb begin
    in_item.mode   = mode_e'(mode_i);
    in_item.now    = now_i;
    in_item.uid    = pkt_uid_i;
    in_item.addr   = src_addr_i;
    in_item.port   = src_port_i;
    in_item.stamp  = time_stamp_i;
    in_item.common = is_common_i;
  end

  cst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (in_item),
    .item_valid_o(f_valid),
    .item_take_i (f_take),
    .item_o      (f_item)
  );

  cst_back #(.SLOTS(SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(f_valid),
    .item_take_o (f_take),
    .item_i      (f_item),
    .res_wr_o    (r_wr),
    .res_o       (r_in),
    .res_full_i  (r_full)
  );

  cst_res_fifo u_res (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (r_wr),
    .wr_data_i(r_in),
    .wr_full_o(r_full),
    .empty    (empty),
    .pop      (pop),
    .rd_data_o(r_out)
  );

  // result ports
  assign action_o    = r_out.action;
  assign uid_o       = r_out.uid;
  assign slot_o      = r_out.slot;
  assign ping_ms_o   = r_out.ping;
  assign dest_addr_o = r_out.addr;
  assign dest_port_o = r_out.port;
  assign last_o      = r_out.last;

endmodule

// File: hdl/cst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks on the result channel of the session table.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  action_o,
  input logic [31:0] uid_o,
  input logic [3:0]  slot_o,
  input logic [31:0] ping_ms_o,
  input logic [31:0] dest_addr_o,
  input logic [15:0] dest_port_o
);
  import cst_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(action_o) && $stable(uid_o)))
    else $error("result changed while stalled");

  // every result carries a real action
  a_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (action_o != ACT_NONE))
    else $error("result without action");

  // reject names no client
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o == ACT_REJECT) |-> (uid_o == 32'd0 && slot_o == 4'd0))
    else $error("reject with client fields");

  // ping time only on alive results
  a_ping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o != ACT_ALIVE) |-> (ping_ms_o == 32'd0))
    else $error("ping time on non-alive result");

  // no destination on local-only results
  a_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (action_o == ACT_DATA_OK || action_o == ACT_STALE ||
                action_o == ACT_ALIVE || action_o == ACT_LEFT))
    |-> (dest_addr_o == 32'd0 && dest_port_o == 16'd0))
    else $error("destination on local result");

endmodule

bind client_session_table_core cst_checker u_cst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .action_o   (action_o),
  .uid_o      (uid_o),
  .slot_o     (slot_o),
  .ping_ms_o  (ping_ms_o),
  .dest_addr_o(dest_addr_o),
  .dest_port_o(dest_port_o)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the client session table: drives packets, sweeps
// and drops through the input queue, predicts every result item from a local
// copy of the table and compares field by field at the result queue.
// ----------------------------------------------------------------------------
module tb_top;
  import cst_pkg::*;

  localparam int NSLOT = 16;

  // one predicted result
  typedef struct {
    act_e        action;
    logic [31:0] uid;
    logic [3:0]  slot;
    logic [31:0] ping;
    logic [31:0] addr;
    logic [15:0] port;
    logic        last;
  } session_res_t;

  // table predictor and store of pending results
  class session_scoreboard;
    logic [4:0]  client_cap;
    logic        allow_conn;
    logic [15:0] tmo, idle_p, min_gap, max_gap;
    int          count;
    logic [31:0] next_uid;
    logic [31:0] s_uid[NSLOT], s_addr[NSLOT], heard[NSLOT], sent[NSLOT];
    logic [31:0] psent[NSLOT], stamp[NSLOT], sping[NSLOT];
    logic [15:0] s_port[NSLOT];
    session_res_t pending[$];
    int          errors;

    function void init();
      client_cap = 5'd16; allow_conn = 1'b1; tmo = 16'd5000; idle_p = 16'd500;
      min_gap = 16'd250; max_gap = 16'd2000; count = 0; next_uid = 32'd0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_CLIENT_CAP:   client_cap = val[4:0];
        REG_ALLOW_CONN:   allow_conn = val[0];
        REG_TIMEOUT:      tmo = val;
        REG_IDLE_PAUSE:   idle_p = val;
        REG_MIN_PING_GAP: min_gap = val;
        REG_MAX_PING_GAP: max_gap = val;
        default: ;
      endcase
    endfunction

    function void add(act_e a, logic [31:0] u, logic [3:0] s, logic [31:0] p,
                      logic [31:0] ad, logic [15:0] po);
      session_res_t r;
      r.action = a; r.uid = u; r.slot = s; r.ping = p; r.addr = ad; r.port = po;
      r.last = 1'b0;
      pending = {pending, r};
    endfunction

    function int find_uid(logic [31:0] u);
      for (int i = 0; i < count; i++) if (s_uid[i] == u) return i;
      return -1;
    endfunction

    function int find_peer(logic [31:0] a, logic [15:0] p);
      for (int i = 0; i < count; i++) if (s_addr[i] == a && s_port[i] == p) return i;
      return -1;
    endfunction

    function void remove(int idx);
      for (int i = idx; i + 1 < count; i++) begin
        s_uid[i] = s_uid[i+1]; s_addr[i] = s_addr[i+1]; s_port[i] = s_port[i+1];
        heard[i] = heard[i+1]; sent[i] = sent[i+1]; psent[i] = psent[i+1];
        stamp[i] = stamp[i+1]; sping[i] = sping[i+1];
      end
      if (count > 0) count--;
    endfunction

    // note an accepted input item and queue what it causes
    function void note_item(mode_e m, logic [31:0] now, logic [31:0] u, logic [31:0] a,
                            logic [15:0] p, logic [31:0] ts, logic com);
      int idx, n0, lim;
      n0 = pending.size();
      case (m)
        MODE_DATA: begin
          idx = find_uid(u);
          if (idx >= 0) begin
            heard[idx] = now;
            if (com && ts < stamp[idx]) add(ACT_STALE, u, 4'(idx), 0, 0, 0);
            else begin
              if (com) stamp[idx] = ts;
              add(ACT_DATA_OK, u, 4'(idx), 0, 0, 0);
            end
          end
        end
        MODE_ALIVE: begin
          idx = find_uid(u);
          if (idx >= 0) begin
            heard[idx] = now;
            sping[idx] = now - psent[idx];
            add(ACT_ALIVE, u, 4'(idx), sping[idx], 0, 0);
          end
        end
        MODE_PING: begin
          idx = find_uid(u);
          if (idx >= 0) begin
            heard[idx] = now; sent[idx] = now;
          end
          add(ACT_REPLY, u, idx >= 0 ? 4'(idx) : 4'd0, 0, a, p);
        end
        MODE_CONNECT: begin
          lim = client_cap > NSLOT ? NSLOT : int'(client_cap);
          if (find_peer(a, p) < 0 && allow_conn && count < lim) begin
            next_uid++;
            s_uid[count] = next_uid; s_addr[count] = a; s_port[count] = p;
            heard[count] = now; sent[count] = now; psent[count] = 0;
            stamp[count] = ts; sping[count] = 0;
            add(ACT_ACCEPT, next_uid, 4'(count), 0, a, p);
            count++;
          end else add(ACT_REJECT, 0, 0, 0, a, p);
        end
        MODE_DISC: begin
          idx = find_peer(a, p);
          if (idx >= 0) begin
            add(ACT_LEFT, s_uid[idx], 4'(idx), 0, 0, 0);
            remove(idx);
          end
        end
        MODE_SWEEP: begin
          for (int i = 0; i < count; i++) begin
            if (now - heard[i] > {16'd0, tmo}) begin
              add(ACT_TIMEOUT, s_uid[i], 4'(i), 0, s_addr[i], s_port[i]);
              remove(i);
              break;
            end
            if ((now - heard[i] > {16'd0, idle_p} && now - sent[i] > {16'd0, min_gap}) ||
                now - psent[i] > {16'd0, max_gap}) begin
              sent[i] = now; psent[i] = now;
              add(ACT_PING, s_uid[i], 4'(i), 0, s_addr[i], s_port[i]);
            end
          end
        end
        MODE_DROP: begin
          idx = find_uid(u);
          if (idx >= 0) begin
            add(ACT_DROPPED, u, 4'(idx), 0, s_addr[idx], s_port[idx]);
            remove(idx);
          end else add(ACT_UNKNOWN, u, 0, 0, 0, 0);
        end
        default: ;
      endcase
      if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [3:0] a, logic [31:0] u, logic [3:0] s,
                               logic [31:0] p, logic [31:0] ad, logic [15:0] po,
                               logic l);
      session_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: action %0d uid %0h", $time, a, u);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a !== e.action) begin
        $display("%0t: action exp %0d act %0d", $time, e.action, a); errors++;
      end
      if (u !== e.uid) begin
        $display("%0t: uid exp %0h act %0h", $time, e.uid, u); errors++;
      end
      if (s !== e.slot) begin
        $display("%0t: slot exp %0d act %0d", $time, e.slot, s); errors++;
      end
      if (p !== e.ping) begin
        $display("%0t: ping exp %0h act %0h", $time, e.ping, p); errors++;
      end
      if (ad !== e.addr) begin
        $display("%0t: addr exp %0h act %0h", $time, e.addr, ad); errors++;
      end
      if (po !== e.port) begin
        $display("%0t: port exp %0h act %0h", $time, e.port, po); errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last exp %0b act %0b", $time, e.last, l); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0, pop = 1'b0;
  logic        full, empty;
  logic [2:0]  mode_i = '0;
  logic [31:0] now_i = '0, pkt_uid_i = '0, src_addr_i = '0, time_stamp_i = '0;
  logic [15:0] src_port_i = '0;
  logic        is_common_i = 1'b0;
  logic [3:0]  action_o, slot_o;
  logic [31:0] uid_o, ping_ms_o, dest_addr_o;
  logic [15:0] dest_port_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  session_scoreboard sb;
  logic        calm;       // no idling in the final part
  logic [31:0] clock_ms;
  logic [31:0] peer_addr[4];
  logic [15:0] peer_port[4];

  client_session_table_core i_dut (.*);

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // timeout guard
  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

  // result side: random pop stalls, check on handshake
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty)
        sb.check_result(action_o, uid_o, slot_o, ping_ms_o, dest_addr_o, dest_port_o,
                        last_o);
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  // send one input item, with an optional random gap first; push stays high
  // after the accept so that the next item can follow at once
  task automatic send_item(mode_e m, logic [31:0] now, logic [31:0] u, logic [31:0] a,
                           logic [15:0] p, logic [31:0] ts, logic com);
    cfg_valid_i <= 1'b0;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push <= 1'b1; mode_i <= m; now_i <= now; pkt_uid_i <= u; src_addr_i <= a;
    src_port_i <= p; time_stamp_i <= ts; is_common_i <= com;
    do @(posedge clk_i); while (full);
    sb.note_item(m, now, u, a, p, ts, com);
  endtask

  // valid stays high after the write; the next item or write takes it over
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  // stop pushing, wait until the block has drained, then a quiet margin
  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // uid of a live client or of a random stranger
  function automatic logic [31:0] pick_uid();
    if (sb.count > 0 && $urandom_range(0, 4) != 0)
      return sb.s_uid[$urandom_range(0, sb.count - 1)];
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    int k;
    mode_e m;
    logic [31:0] u;
    for (int i = 0; i < n; i++) begin
      clock_ms += $urandom_range(0, 1500);
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
      k = $urandom_range(0, 3);
      u = pick_uid();
      case ($urandom_range(0, 15))
        0, 1, 2:  m = MODE_DATA;
        3, 4:     m = MODE_ALIVE;
        5:        m = MODE_PING;
        6, 7, 8:  m = MODE_CONNECT;
        9:        m = MODE_DISC;
        10, 11, 12: m = MODE_SWEEP;
        13:       m = MODE_DROP;
        14:       m = MODE_RSVD;
        default:  m = mode_e'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 3) == 0)
        send_item(m, clock_ms, u, $urandom(), 16'($urandom()), $urandom(),
                  1'($urandom()));
      else
        send_item(m, clock_ms, u, peer_addr[k] ^ ($urandom_range(0, 3) == 0 ?
                  32'h1 << $urandom_range(0, 31) : 32'h0), peer_port[k],
                  clock_ms + $urandom_range(0, 40) - 20, 1'($urandom()));
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    sb.init();
    calm = 1'b0;
    clock_ms = 32'd1000;
    for (int k = 0; k < 4; k++) begin
      peer_addr[k] = $urandom();
      peer_port[k] = 16'($urandom());
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and every mode
    send_item(MODE_CONNECT, 32'd1000, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_CONNECT, 32'd1000, 0, 32'h0, 16'h0, 32'd50, 1'b0);
    send_item(MODE_CONNECT, 32'd1000, 0, 32'h0, 16'h0, 32'd50, 1'b0);
    send_item(MODE_DATA, 32'd1010, 32'd2, 0, 0, 32'd40, 1'b1);
    send_item(MODE_DATA, 32'd1011, 32'd2, 0, 0, 32'd40, 1'b0);
    send_item(MODE_DATA, 32'd1012, 32'd2, 0, 0, 32'd60, 1'b1);
    send_item(MODE_DATA, 32'd1013, 32'd9, 0, 0, 32'd60, 1'b1);
    send_item(MODE_ALIVE, 32'd1020, 32'd1, 0, 0, 0, 1'b0);
    send_item(MODE_ALIVE, 32'd1020, 32'd77, 0, 0, 0, 1'b0);
    send_item(MODE_PING, 32'd1030, 32'd1, 32'h1234, 16'h55, 0, 1'b0);
    send_item(MODE_PING, 32'd1030, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b1);
    send_item(MODE_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
              32'hFFFF_FFFF, 1'b1);
    send_item(MODE_SWEEP, 32'd1600, 0, 0, 0, 0, 1'b0);
    send_item(MODE_SWEEP, 32'd3500, 0, 0, 0, 0, 1'b0);
    send_item(MODE_SWEEP, 32'd9000, 0, 0, 0, 0, 1'b0);
    send_item(MODE_DISC, 32'd9000, 0, 32'h0, 16'h0, 0, 1'b0);
    send_item(MODE_DISC, 32'd9000, 0, 32'h0, 16'h0, 0, 1'b0);
    send_item(MODE_CONNECT, 32'd9100, 0, 32'h10, 16'h10, 0, 1'b0);
    send_item(MODE_DROP, 32'd9100, 32'd3, 0, 0, 0, 1'b0);
    send_item(MODE_DROP, 32'd9100, 32'd3, 0, 0, 0, 1'b0);
    drain();

    // tight limits, connections closed, full table, sweeps with many pings
    write_reg(REG_CLIENT_CAP, 16'd31);
    write_reg(REG_ALLOW_CONN, 16'd0);
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_IDLE_PAUSE, 16'd0);
    write_reg(REG_MIN_PING_GAP, 16'd0);
    write_reg(REG_MAX_PING_GAP, 16'd0);
    send_item(MODE_CONNECT, 32'd9200, 0, 32'h20, 16'h20, 0, 1'b0);
    drain();
    write_reg(REG_ALLOW_CONN, 16'd1);
    for (int i = 0; i < 17; i++)
      send_item(MODE_CONNECT, 32'd9200, 0, 32'h100 + i, 16'(i), 0, 1'b0);
    send_item(MODE_SWEEP, 32'd9300, 0, 0, 0, 0, 1'b0);
    send_item(MODE_SWEEP, 32'd9400, 0, 0, 0, 0, 1'b0);
    drain();

    // several settings with random items
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_CLIENT_CAP, ph == 0 ? 16'd0 : 16'($urandom_range(1, 16)));
      write_reg(REG_ALLOW_CONN, 16'($urandom_range(0, 4) != 0));
      write_reg(REG_TIMEOUT, ph == 4 ? 16'd0 : 16'($urandom_range(1000, 65535)));
      write_reg(REG_IDLE_PAUSE, 16'($urandom()));
      write_reg(REG_MIN_PING_GAP, 16'($urandom_range(0, 3000)));
      write_reg(REG_MAX_PING_GAP, ph == 2 ? 16'hFFFF : 16'($urandom_range(0, 8000)));
      if (ph == 4) calm = 1'b1;
      random_phase(ph == 0 ? 10 : 25);
      drain();
    end

    if (sb.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
